// File: rtl/goodness_epoch_scheduler_core_assert.svh
// Assertion macros used by the scheduler core.
`ifndef GOODNESS_EPOCH_SCHEDULER_CORE_ASSERT_SVH
`define GOODNESS_EPOCH_SCHEDULER_CORE_ASSERT_SVH
`define GES_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define GES_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`endif

// File: rtl/ges_pkg.sv
package ges_pkg;
   localparam int NUM_PROCS_DEF = 32;
   localparam int PID_W = 5;
   localparam int VAL_W = 10;
   localparam int PRIO_W = 8;
   localparam logic [VAL_W-1:0] VAL_MAX = 10'd1023;
   localparam logic [VAL_W-1:0] QUANTUM_RESET = 10'd10;

   typedef enum logic [1:0] {
      ST_FREE = 2'd0,
      ST_READY = 2'd1,
      ST_CURR = 2'd2,
      ST_WAIT = 2'd3
   } status_type;

   typedef enum logic {
      CMD_SET = 1'b0,
      CMD_RESCHED = 1'b1
   } cmd_type;

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SCAN,
      PH_EPOCH,
      PH_PICK,
      PH_COMMIT,
      PH_RESP
   } phase_type;

   // Control broadcast from the sequencer to every cell.
   typedef struct packed {
      logic shift;
      logic epoch;
      logic park;
      logic set_wr;
      logic [PID_W-1:0] set_pid;
      status_type set_status;
      logic [PRIO_W-1:0] set_prio;
      logic cur_wr;
      logic [VAL_W-1:0] cur_counter;
      logic commit;
   } cell_ctrl_type;

   function automatic logic [VAL_W-1:0] sat_add(input logic [PRIO_W-1:0] a,
                                                 input logic [VAL_W-1:0] b);
      logic [VAL_W:0] s;
      s = {{(VAL_W-PRIO_W+1){1'b0}}, a} + {1'b0, b};
      return s[VAL_W] ? VAL_MAX : s[VAL_W-1:0];
   endfunction
endpackage

// File: rtl/ges_cell.sv
module ges_cell #(
   parameter int NUM_PROCS = 32,
   parameter int IDX_W = 5,
   parameter int ID = 0
) (
   input  logic clock,
   input  logic reset,
   input  ges_pkg::cell_ctrl_type ctrl,
   input  logic [IDX_W-1:0] cur_idx,
   input  logic [IDX_W-1:0] pick_idx,
   input  logic [IDX_W-1:0] up_id,
   input  ges_pkg::status_type up_status,
   input  logic [ges_pkg::PRIO_W-1:0] up_prio,
   input  logic [ges_pkg::VAL_W-1:0] up_counter,
   input  logic [ges_pkg::VAL_W-1:0] up_good,
   output logic [IDX_W-1:0] id_out,
   output ges_pkg::status_type status_out,
   output logic [ges_pkg::PRIO_W-1:0] prio_out,
   output logic [ges_pkg::VAL_W-1:0] counter_out,
   output logic [ges_pkg::VAL_W-1:0] good_out
);
   import ges_pkg::*;

   logic [IDX_W-1:0] id_ff, id_in;
   status_type status_ff, status_in;
   logic [PRIO_W-1:0] prio_ff, prio_in;
   logic [VAL_W-1:0] counter_ff, counter_in, good_ff, good_in;

   always_comb begin
      id_in = id_ff;
      status_in = status_ff;
      prio_in = prio_ff;
      counter_in = counter_ff;
      good_in = good_ff;
      if (ctrl.shift) begin
         id_in = up_id;
         status_in = up_status;
         prio_in = up_prio;
         counter_in = up_counter;
         good_in = up_good;
         if (ctrl.epoch && up_status != ST_FREE) begin
            counter_in = sat_add(up_prio, {1'b0, up_counter[VAL_W-1:1]});
            good_in = sat_add(up_prio, counter_in);
         end
      end else if (ctrl.park) begin
         if (ctrl.set_wr && {{(8-PID_W){1'b0}}, ctrl.set_pid} < 8'(NUM_PROCS)
             && id_ff == ctrl.set_pid[IDX_W-1:0]) begin
            status_in = ctrl.set_status;
            prio_in = ctrl.set_prio;
         end
         if (ctrl.cur_wr && id_ff == cur_idx && status_ff == ST_CURR) begin
            status_in = ST_READY;
            counter_in = ctrl.cur_counter;
            good_in = (ctrl.cur_counter != '0) ? sat_add(prio_ff, ctrl.cur_counter) : '0;
         end
         if (ctrl.commit && id_ff == pick_idx) status_in = ST_CURR;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff <= ST_FREE;
         prio_ff <= '0;
         counter_ff <= '0;
         good_ff <= '0;
      end else begin
         status_ff <= status_in;
         prio_ff <= prio_in;
         counter_ff <= counter_in;
         good_ff <= good_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) id_ff <= IDX_W'(ID);
      else id_ff <= id_in;
   end

   assign id_out = id_ff;
   assign status_out = status_ff;
   assign prio_out = prio_ff;
   assign counter_out = counter_ff;
   assign good_out = good_ff;
endmodule

// File: rtl/ges_ring.sv
module ges_ring #(
   parameter int NUM_PROCS = 32,
   parameter int IDX_W = 5
) (
   input  logic clock,
   input  logic reset,
   input  ges_pkg::cell_ctrl_type ctrl,
   input  logic [IDX_W-1:0] cur_idx,
   input  logic [IDX_W-1:0] pick_idx,
   output logic [IDX_W-1:0] head_id,
   output ges_pkg::status_type head_status,
   output logic [ges_pkg::VAL_W-1:0] head_counter,
   output logic [ges_pkg::VAL_W-1:0] head_good
);
   import ges_pkg::*;

   logic [IDX_W-1:0] id_w [NUM_PROCS];
   status_type st_w [NUM_PROCS];
   logic [PRIO_W-1:0] pr_w [NUM_PROCS];
   logic [VAL_W-1:0] cn_w [NUM_PROCS];
   logic [VAL_W-1:0] gd_w [NUM_PROCS];

   // Cell k holds entry k after reset; the ring rotates one place per shift.
   // The epoch update is applied only where an entry wraps round from the head
   // to the tail, so that each entry is updated once per pass.
   for (genvar k = 0; k < NUM_PROCS; k++) begin : g_cell
      localparam int UP = (k + 1) % NUM_PROCS;
      cell_ctrl_type cell_ctrl;
      always_comb begin
         cell_ctrl = ctrl;
         if (k != NUM_PROCS - 1) cell_ctrl.epoch = 1'b0;
      end
      ges_cell #(.NUM_PROCS(NUM_PROCS), .IDX_W(IDX_W), .ID(k)) u_cell (
         .clock, .reset, .ctrl(cell_ctrl), .cur_idx, .pick_idx,
         .up_id(id_w[UP]), .up_status(st_w[UP]), .up_prio(pr_w[UP]),
         .up_counter(cn_w[UP]), .up_good(gd_w[UP]),
         .id_out(id_w[k]), .status_out(st_w[k]), .prio_out(pr_w[k]),
         .counter_out(cn_w[k]), .good_out(gd_w[k]));
   end

   assign head_id = id_w[0];
   assign head_status = st_w[0];
   assign head_counter = cn_w[0];
   assign head_good = gd_w[0];
endmodule

// File: rtl/goodness_epoch_scheduler_core.sv
// Order: a set item gives its result in the cycle after its transfer; a reschedule
// runs an update cycle, a scan pass, an epoch pass when one is needed, a pick
// pass and a commit before its result.
// Throughput: one item at a time; the next is taken the cycle after the result.
// Reset: synchronous, active high; all entries free and zero, current id 0,
// default quantum 10; items are taken in the first cycle after reset.
module goodness_epoch_scheduler_core #(
   parameter int NUM_PROCS = ges_pkg::NUM_PROCS_DEF
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic req_cmd,
   input  logic [ges_pkg::PID_W-1:0] req_pid,
   input  logic [1:0] req_status,
   input  logic [ges_pkg::PRIO_W-1:0] req_priority_req,
   input  logic signed [ges_pkg::VAL_W-1:0] req_remaining_ticks,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic [ges_pkg::PID_W-1:0] rsp_next_pid,
   output logic [ges_pkg::VAL_W-1:0] rsp_time_slice,
   output logic rsp_new_epoch,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [ges_pkg::VAL_W-1:0] csr_default_quantum
);
   import ges_pkg::*;
   `include "goodness_epoch_scheduler_core_assert.svh"

   localparam int IDX_W = (NUM_PROCS > 1) ? $clog2(NUM_PROCS) : 1;
   localparam int CNT_W = $clog2(NUM_PROCS + 1);

   phase_type ph_ff, ph_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [VAL_W-1:0] quantum_ff;
   logic [IDX_W-1:0] cur_ff, cur_in, best_ff, best_in;
   logic [VAL_W-1:0] bestg_ff, bestg_in, bestc_ff, bestc_in;
   logic any_ff, any_in, epoch_ff, epoch_in;
   logic [PID_W-1:0] opid_ff, opid_in;
   logic [VAL_W-1:0] oslice_ff, oslice_in;
   logic cmd_ff, park_ff;
   logic [PID_W-1:0] pid_ff;
   status_type st_ff;
   logic [PRIO_W-1:0] prio_ff;
   logic [VAL_W-1:0] ticks_ff;
   cell_ctrl_type ctrl;
   logic [IDX_W-1:0] h_id;
   status_type h_st;
   logic [VAL_W-1:0] h_cn, h_gd;
   logic runnable, accept, last;

   ges_ring #(.NUM_PROCS(NUM_PROCS), .IDX_W(IDX_W)) u_ring (
      .clock, .reset, .ctrl, .cur_idx(cur_ff), .pick_idx(best_ff),
      .head_id(h_id), .head_status(h_st), .head_counter(h_cn), .head_good(h_gd));

   assign accept = req_valid && req_ready;
   assign req_ready = (ph_ff == PH_IDLE) && !park_ff;
   assign csr_ready = 1'b1;
   assign runnable = (h_st == ST_READY) || (h_st == ST_CURR);
   assign last = (cnt_ff == CNT_W'(NUM_PROCS - 1));

   always_comb begin
      ph_in = ph_ff;
      unique case (ph_ff)
         PH_IDLE: if (accept) ph_in = (req_cmd == CMD_RESCHED) ? PH_SCAN : PH_RESP;
         PH_SCAN: if (last && !park_ff)
            ph_in = (any_ff || (runnable && h_gd != '0)) ? PH_PICK : PH_EPOCH;
         PH_EPOCH: if (last) ph_in = PH_PICK;
         PH_PICK: if (last) ph_in = PH_COMMIT;
         PH_COMMIT: ph_in = PH_RESP;
         PH_RESP: if (rsp_ready) ph_in = PH_IDLE;
         default: ph_in = PH_IDLE;
      endcase
   end

   always_comb begin
      cnt_in = cnt_ff;
      any_in = any_ff;
      epoch_in = epoch_ff;
      best_in = best_ff;
      bestg_in = bestg_ff;
      bestc_in = bestc_ff;
      cur_in = cur_ff;
      opid_in = opid_ff;
      oslice_in = oslice_ff;
      ctrl = '0;
      ctrl.set_pid = pid_ff;
      ctrl.set_status = st_ff;
      ctrl.set_prio = prio_ff;
      ctrl.cur_counter = ticks_ff[VAL_W-1] ? '0 : ticks_ff;
      ctrl.park = park_ff;
      ctrl.set_wr = park_ff && (cmd_ff == CMD_SET);
      ctrl.cur_wr = park_ff && (cmd_ff == CMD_RESCHED);
      unique case (ph_ff)
         PH_IDLE: begin
            cnt_in = '0;
            any_in = 1'b0;
            epoch_in = 1'b0;
            best_in = '0;
            bestg_in = '0;
            bestc_in = '0;
            opid_in = PID_W'(cur_ff);
            oslice_in = '0;
         end
         PH_SCAN, PH_EPOCH, PH_PICK: begin
            if (!park_ff) begin
               ctrl.shift = 1'b1;
               ctrl.epoch = (ph_ff == PH_EPOCH);
               if (ph_ff == PH_SCAN && runnable && h_gd != '0) any_in = 1'b1;
               if (ph_ff == PH_EPOCH) epoch_in = 1'b1;
               if (ph_ff == PH_PICK && runnable &&
                   (h_gd > bestg_ff || (h_gd == bestg_ff && h_gd != '0 && h_id < best_ff))) begin
                  best_in = h_id;
                  bestg_in = h_gd;
                  bestc_in = h_cn;
               end
               cnt_in = last ? '0 : cnt_ff + 1'b1;
            end
         end
         PH_COMMIT: begin
            ctrl.park = 1'b1;
            ctrl.commit = 1'b1;
            if (bestg_ff == '0 || best_ff == '0) begin
               best_in = '0;
               cur_in = '0;
               oslice_in = quantum_ff;
            end else begin
               cur_in = best_ff;
               oslice_in = bestc_ff;
            end
            opid_in = PID_W'(cur_in);
         end
         PH_RESP: ;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ph_ff <= PH_IDLE;
         cnt_ff <= '0;
         cur_ff <= '0;
         quantum_ff <= QUANTUM_RESET;
         park_ff <= 1'b0;
         any_ff <= 1'b0;
         epoch_ff <= 1'b0;
      end else begin
         ph_ff <= ph_in;
         cnt_ff <= cnt_in;
         cur_ff <= cur_in;
         any_ff <= any_in;
         epoch_ff <= epoch_in;
         park_ff <= accept;
         if (csr_valid) quantum_ff <= csr_default_quantum;
      end
   end

   always_ff @(posedge clock) begin
      best_ff <= best_in;
      bestg_ff <= bestg_in;
      bestc_ff <= bestc_in;
      opid_ff <= opid_in;
      oslice_ff <= oslice_in;
      if (accept) begin
         cmd_ff <= req_cmd;
         pid_ff <= req_pid;
         st_ff <= status_type'(req_status);
         prio_ff <= req_priority_req;
         ticks_ff <= req_remaining_ticks;
      end
   end

   assign rsp_valid = (ph_ff == PH_RESP);
   assign rsp_next_pid = opid_ff;
   assign rsp_time_slice = oslice_ff;
   assign rsp_new_epoch = epoch_ff;

   `GES_ASSERT_NEXT(a_accept_idle, clock, reset, accept, ph_ff != PH_IDLE, "accept left idle")
   `GES_ASSERT_IMPL(a_no_ready_busy, clock, reset, ph_ff != PH_IDLE, !req_ready, "ready while busy")
   `GES_ASSERT_NEXT(a_commit_resp, clock, reset, ph_ff == PH_COMMIT, rsp_valid, "no result after commit")
   `GES_ASSERT_IMPL(a_epoch_set, clock, reset, rsp_valid && cmd_ff == CMD_SET, !rsp_new_epoch, "epoch on set")
endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import ges_pkg::*;

   localparam int PROCS = 32;
   localparam int CYCLE_LIMIT = 600000;

   typedef struct {
      logic [PID_W-1:0] next_pid;
      logic [VAL_W-1:0] time_slice;
      logic new_epoch;
   } sched_result_type;

   class sched_scoreboard_type;
      status_type proc_st[PROCS];
      logic [PRIO_W-1:0] proc_prio[PROCS];
      logic [VAL_W-1:0] proc_cnt[PROCS];
      logic [VAL_W-1:0] proc_good[PROCS];
      logic [PID_W-1:0] running;
      logic [VAL_W-1:0] quantum;
      sched_result_type awaited[$];
      int errors;

      function new();
         for (int i = 0; i < PROCS; i++) begin
            proc_st[i] = ST_FREE;
            proc_prio[i] = '0;
            proc_cnt[i] = '0;
            proc_good[i] = '0;
         end
         running = '0;
         quantum = QUANTUM_RESET;
         errors = 0;
      endfunction

      function logic [VAL_W-1:0] clip(int v);
         return (v > int'(VAL_MAX)) ? VAL_MAX : v[VAL_W-1:0];
      endfunction

      function bit can_run(int i);
         return proc_st[i] == ST_READY || proc_st[i] == ST_CURR;
      endfunction

      function void note_request(cmd_type cmd, logic [PID_W-1:0] pid, status_type st,
                                 logic [PRIO_W-1:0] prio, logic signed [VAL_W-1:0] ticks);
         sched_result_type r;
         bit live;
         int pick;
         int top;
         int c;
         r.next_pid = running;
         r.time_slice = '0;
         r.new_epoch = 1'b0;
         if (cmd == CMD_SET) begin
            proc_st[pid] = st;
            proc_prio[pid] = prio;
            awaited.push_back(r);
            return;
         end
         if (proc_st[running] == ST_CURR) begin
            c = (ticks < 0) ? 0 : int'(ticks);
            proc_st[running] = ST_READY;
            proc_cnt[running] = c[VAL_W-1:0];
            proc_good[running] = (c > 0) ? clip(int'(proc_prio[running]) + c) : '0;
         end
         live = 0;
         for (int i = 0; i < PROCS; i++)
            if (can_run(i) && proc_good[i] != 0) live = 1;
         if (!live) begin
            r.new_epoch = 1'b1;
            for (int i = 0; i < PROCS; i++) begin
               if (proc_st[i] != ST_FREE) begin
                  proc_cnt[i] = clip(int'(proc_prio[i]) + int'(proc_cnt[i]) / 2);
                  proc_good[i] = clip(int'(proc_prio[i]) + int'(proc_cnt[i]));
               end
            end
         end
         pick = 0;
         top = 0;
         for (int i = 0; i < PROCS; i++) begin
            if (can_run(i) && int'(proc_good[i]) > top) begin
               top = int'(proc_good[i]);
               pick = i;
            end
         end
         if (top == 0 || pick == 0) begin
            running = '0;
            proc_st[0] = ST_CURR;
            r.time_slice = quantum;
         end else begin
            running = pick[PID_W-1:0];
            proc_st[pick] = ST_CURR;
            r.time_slice = proc_cnt[pick];
         end
         r.next_pid = running;
         awaited.push_back(r);
      endfunction

      function void check_response(logic [PID_W-1:0] pid, logic [VAL_W-1:0] slice,
                                   logic epoch);
         sched_result_type r;
         if (awaited.size() == 0) begin
            $error("unexpected response transfer: next_pid %0d", pid);
            errors++;
            return;
         end
         r = awaited.pop_front();
         if (pid !== r.next_pid) begin
            $error("next_pid: expected %0d, actual %0d", r.next_pid, pid);
            errors++;
         end
         if (slice !== r.time_slice) begin
            $error("time_slice: expected %0d, actual %0d", r.time_slice, slice);
            errors++;
         end
         if (epoch !== r.new_epoch) begin
            $error("new_epoch: expected %0d, actual %0d", r.new_epoch, epoch);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_cmd = 1'b0;
   logic [PID_W-1:0] req_pid = '0;
   logic [1:0] req_status = '0;
   logic [PRIO_W-1:0] req_priority_req = '0;
   logic signed [VAL_W-1:0] req_remaining_ticks = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [PID_W-1:0] rsp_next_pid;
   logic [VAL_W-1:0] rsp_time_slice;
   logic rsp_new_epoch;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [VAL_W-1:0] csr_default_quantum = '0;

   sched_scoreboard_type sb = new();
   bit quiet = 0;
   int cycles = 0;
   int rsp_count = 0;

   goodness_epoch_scheduler_core i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_cmd(req_cmd),
      .req_pid(req_pid),
      .req_status(req_status),
      .req_priority_req(req_priority_req),
      .req_remaining_ticks(req_remaining_ticks),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_next_pid(rsp_next_pid),
      .rsp_time_slice(rsp_time_slice),
      .rsp_new_epoch(rsp_new_epoch),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_default_quantum(csr_default_quantum)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("[goodness_epoch_scheduler_core] ERROR");
         $finish;
      end
   end

   task automatic send_item(cmd_type cmd, logic [PID_W-1:0] pid, status_type st,
                            logic [PRIO_W-1:0] prio, logic signed [VAL_W-1:0] ticks);
      int gap;
      gap = quiet ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_pid <= pid;
      req_status <= st;
      req_priority_req <= prio;
      req_remaining_ticks <= ticks;
      do @(posedge clock); while (!req_ready);
      sb.note_request(cmd, pid, st, prio, ticks);
   endtask

   task automatic set_entry(logic [PID_W-1:0] pid, status_type st, logic [PRIO_W-1:0] prio);
      send_item(CMD_SET, pid, st, prio, VAL_W'($urandom));
   endtask

   task automatic resched(logic signed [VAL_W-1:0] ticks);
      send_item(CMD_RESCHED, PID_W'($urandom), status_type'(2'($urandom)),
                PRIO_W'($urandom), ticks);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.awaited.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_quantum(logic [VAL_W-1:0] q);
      csr_valid <= 1'b1;
      csr_default_quantum <= q;
      do @(posedge clock); while (!csr_ready);
      sb.quantum = q;
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic random_item();
      logic [PID_W-1:0] pid;
      status_type st;
      logic signed [VAL_W-1:0] ticks;
      int k;
      k = $urandom_range(0, 99);
      if (k < 40) begin
         pid = ($urandom_range(0, 3) == 0) ? PID_W'($urandom) : PID_W'($urandom_range(0, 7));
         case ($urandom_range(0, 9))
            0: st = ST_FREE;
            1: st = ST_CURR;
            2, 3: st = ST_WAIT;
            default: st = ST_READY;
         endcase
         set_entry(pid, st, ($urandom_range(0, 4) == 0) ? PRIO_W'($urandom)
                                                         : PRIO_W'($urandom_range(0, 20)));
      end else begin
         ticks = ($urandom_range(0, 2) == 0) ? VAL_W'($urandom) : VAL_W'($urandom_range(0, 12));
         resched(ticks);
      end
   endtask

   initial begin
      do @(posedge clock); while (reset);
      forever begin
         if (rsp_count == 150) begin
            rsp_ready <= 1'b0;
            repeat (400) @(posedge clock);
         end else begin
            int n;
            n = quiet ? 0 : $urandom_range(0, 9);
            if (n > 0) begin
               rsp_ready <= 1'b0;
               repeat (n) @(posedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         sb.check_response(rsp_next_pid, rsp_time_slice, rsp_new_epoch);
         rsp_count++;
      end
   end

   initial begin
      logic [VAL_W-1:0] q;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      resched(10'sd0);
      set_entry(5'd31, ST_READY, 8'd255);
      set_entry(5'd1, ST_READY, 8'd0);
      set_entry(5'd2, ST_WAIT, 8'd200);
      set_entry(5'd3, ST_CURR, 8'd7);
      resched(10'sd0);
      resched(10'sd511);
      resched(-10'sd512);
      resched(-10'sd1);
      set_entry(5'd31, ST_FREE, 8'd0);
      resched(10'sd5);
      set_entry(5'd0, ST_READY, 8'd3);
      resched(10'sd1);
      set_entry(5'd16, ST_READY, 8'd128);
      resched(10'sd0);
      resched(10'sd0);
      set_entry(5'd2, ST_READY, 8'd200);
      resched(10'sd300);
      drain();

      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: q = 10'd1023;
            1: q = 10'd0;
            2: q = 10'd1;
            default: q = VAL_W'($urandom_range(1, 1023));
         endcase
         write_quantum(q);
         quiet = (ph == 2);
         for (int n = 0; n < 108; n++) random_item();
         drain();
      end

      if (sb.errors == 0)
         $display("[goodness_epoch_scheduler_core] OK");
      else
         $display("[goodness_epoch_scheduler_core] ERROR");
      $finish;
   end
endmodule
